@@ rtl/tccs_pkg.sv @@
// Shared constants, types and state codes for the touch calibrate/scale unit.
// No dependencies; every other file of the block imports this package.
package tccs_pkg;

  localparam int SAMPLE_W  = 10;  // width of the raw sample field
  localparam int POS_W     = 10;  // width of the x/y position fields
  localparam int COUNT_W   = 16;  // touch counter width
  localparam int CFG_W     = 10;  // screen size register width
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam int SAMPLES_PER_AXIS_DEF = 5;
  localparam int ADC_BITS_DEF         = 10;

  localparam int SCREEN_WIDTH_RST  = 320;
  localparam int SCREEN_HEIGHT_RST = 240;

  // default calibration bounds
  localparam int DEF_X_MIN = 200;
  localparam int DEF_X_MAX = 750;
  localparam int DEF_Y_MIN = 120;
  localparam int DEF_Y_MAX = 620;

  // input command codes
  localparam logic CMD_SAMPLE    = 1'b0;
  localparam logic CMD_START_CAL = 1'b1;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_CHECK,
    ST_MUL_X,
    ST_DIVS_X,
    ST_MUL_Y,
    ST_DIVS_Y,
    ST_OUT
  } state_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

@@ rtl/tccs_if.sv @@
// Handshake channels of the touch calibrate/scale unit: sample words in,
// result words out. Depends on tccs_pkg.
interface tccs_sample_if;
  import tccs_pkg::*;

  logic                valid;
  logic                ready;
  logic                command;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, command, sample, input ready);
  modport sink   (input valid, command, sample, output ready);
endinterface

interface tccs_result_if;
  import tccs_pkg::*;

  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   x_pos;
  logic [POS_W-1:0]   y_pos;
  logic               valid_res;
  logic               calibration_touch;
  logic               calibration_done;
  logic [COUNT_W-1:0] touch_count;

  modport source (output valid, x_pos, y_pos, valid_res, calibration_touch,
                  calibration_done, touch_count, input ready);
  modport sink   (input valid, x_pos, y_pos, valid_res, calibration_touch,
                  calibration_done, touch_count, output ready);
endinterface

@@ rtl/tccs_serial_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on tccs_pkg (unit_status_t).
module tccs_serial_div #(
  parameter int DW = tccs_pkg::CFG_W + tccs_pkg::ADC_BITS_DEF,
  parameter int VW = tccs_pkg::ADC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DW-1:0]          dividend,
  input  logic [VW-1:0]          divisor,
  output tccs_pkg::unit_status_t status,
  output logic [DW-1:0]          quotient
);
  import tccs_pkg::*;

  localparam int CNT_W = $clog2(DW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DW - 1);

  logic [DW-1:0]    num;       // dividend bits out the top, quotient bits in
  logic [VW-1:0]    rem;
  logic [VW-1:0]    den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;
  logic [VW-1:0]    rem_next;
  logic [DW-1:0]    num_next;

  always_comb begin
    trial    = {rem, num[DW-1]};
    diff     = trial - {1'b0, den};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];
    num_next = {num[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = num;

endmodule

@@ rtl/tccs_serial_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on tccs_pkg (unit_status_t).
module tccs_serial_mul #(
  parameter int MW = tccs_pkg::CFG_W,
  parameter int AW = tccs_pkg::ADC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [MW-1:0]          multiplier,
  input  logic [AW-1:0]          multiplicand,
  output tccs_pkg::unit_status_t status,
  output logic [MW+AW-1:0]       product
);
  import tccs_pkg::*;

  localparam int CNT_W = $clog2(MW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MW - 1);

  logic [MW+AW-1:0] prod;   // upper part accumulates, lower part shifts out
  logic [AW-1:0]    mcand;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [AW:0]      acc_sum;
  logic [MW+AW-1:0] prod_next;

  always_comb begin
    acc_sum   = {1'b0, prod[MW+AW-1:MW]} + (prod[0] ? {1'b0, mcand} : '0);
    prod_next = {acc_sum, prod[MW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= {{AW{1'b0}}, multiplier};
      mcand <= multiplicand;
    end else if (busy) begin
      prod <= prod_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign product     = prod;

endmodule

@@ rtl/tccs_apb_regs.sv @@
// APB register file holding the screen width and height.
// Depends on tccs_pkg (register indexes, widths, reset values).
module tccs_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tccs_pkg::PADDR_W-1:0]  paddr,
  input  logic [tccs_pkg::PDATA_W-1:0]  pwdata,
  output logic [tccs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [tccs_pkg::CFG_W-1:0]    screen_width,
  output logic [tccs_pkg::CFG_W-1:0]    screen_height
);
  import tccs_pkg::*;

  reg_index_t reg_sel;
  logic       wr;

  assign reg_sel = reg_index_t'(paddr[2]);
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= CFG_W'(SCREEN_WIDTH_RST);
      screen_height <= CFG_W'(SCREEN_HEIGHT_RST);
    end else if (wr) begin
      case (reg_sel)
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[CFG_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCREEN_WIDTH:  prdata = PDATA_W'(screen_width);
      REG_SCREEN_HEIGHT: prdata = PDATA_W'(screen_height);
      default:           prdata = '0;
    endcase
  end

endmodule

@@ rtl/touch_coordinate_calibrate_scale_unit.sv @@
// Touch averaging, two-point calibration and linear scaling to screen pixels.
// Non-final samples and start commands are taken without holding input. The last
// sample of a touch holds input for two serial divides by the sample count, and
// when the point is scaled also for two serial multiplies and two serial divides
// (the divide of an axis whose span is zero is skipped), and until the result can go out.
// Reset (rst, synchronous) restores default bounds and screen size, arms calibration.
module touch_coordinate_calibrate_scale_unit #(
  parameter int SAMPLES_PER_AXIS = tccs_pkg::SAMPLES_PER_AXIS_DEF,
  parameter int ADC_BITS         = tccs_pkg::ADC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  tccs_sample_if.sink                   samples,
  tccs_result_if.source                 results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tccs_pkg::PADDR_W-1:0]  paddr,
  input  logic [tccs_pkg::PDATA_W-1:0]  pwdata,
  output logic [tccs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import tccs_pkg::*;

  localparam int SUM_W = $clog2(SAMPLES_PER_AXIS * ((1 << ADC_BITS) - 1) + 1);
  localparam int IDX_W = $clog2(2 * SAMPLES_PER_AXIS);
  localparam int DIV_W = CFG_W + ADC_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(2 * SAMPLES_PER_AXIS - 1);
  localparam logic [IDX_W-1:0] Y_IDX    = IDX_W'(SAMPLES_PER_AXIS);

  // configuration
  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;

  tccs_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  // control and state
  state_t              state;
  state_t              state_next;
  logic [IDX_W-1:0]    idx;
  logic [SUM_W-1:0]    x_sum;
  logic [SUM_W-1:0]    y_sum;
  logic [ADC_BITS-1:0] x_min, x_max, y_min, y_max;
  logic [ADC_BITS-1:0] first_x, first_y;
  logic                first_taken;
  logic                calibrating;
  logic [COUNT_W-1:0]  touches;
  logic                out_valid;

  // payload
  logic [ADC_BITS-1:0] ax, ay;
  logic [POS_W-1:0]    xo, yo;
  logic                valid_q, cal_touch_q, cal_done_q;

  // arithmetic units
  logic                div_start;
  logic [DIV_W-1:0]    div_num;
  logic [ADC_BITS-1:0] div_den;
  logic [DIV_W-1:0]    div_q;
  unit_status_t        div_st;
  logic                mul_start;
  logic [CFG_W-1:0]    mul_a;
  logic [ADC_BITS-1:0] mul_b;
  logic [DIV_W-1:0]    mul_p;
  unit_status_t        mul_st;

  tccs_serial_div #(.DW(DIV_W), .VW(ADC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .status   (div_st),
    .quotient (div_q)
  );

  tccs_serial_mul #(.MW(CFG_W), .AW(ADC_BITS)) u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplier   (mul_a),
    .multiplicand (mul_b),
    .status       (mul_st),
    .product      (mul_p)
  );

  // decode
  logic                accept;
  logic                is_cmd;
  logic                last;
  logic [ADC_BITS-1:0] s;
  logic                in_range;
  logic [ADC_BITS-1:0] span_x, span_y;
  logic                span_x_zero, span_y_zero;
  logic                out_free;

  assign accept      = samples.valid && samples.ready;
  assign is_cmd      = samples.command == CMD_START_CAL;
  assign s           = ADC_BITS'(samples.sample);
  assign last        = accept && !is_cmd && (idx == LAST_IDX);
  assign in_range    = !calibrating && (ax >= x_min) && (ax <= x_max) &&
                       (ay >= y_min) && (ay <= y_max);
  assign span_x      = x_max - x_min;
  assign span_y      = y_max - y_min;
  assign span_x_zero = span_x == '0;
  assign span_y_zero = span_y == '0;
  assign out_free    = !out_valid || results.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (last) state_next = ST_DIV_X;
      ST_DIV_X:  if (div_st.done) state_next = ST_DIV_Y;
      ST_DIV_Y:  if (div_st.done) state_next = ST_CHECK;
      ST_CHECK:  state_next = in_range ? ST_MUL_X : ST_OUT;
      ST_MUL_X:  if (mul_st.done) state_next = span_x_zero ? ST_MUL_Y : ST_DIVS_X;
      ST_DIVS_X: if (div_st.done) state_next = ST_MUL_Y;
      ST_MUL_Y:  if (mul_st.done) state_next = span_y_zero ? ST_OUT : ST_DIVS_Y;
      ST_DIVS_Y: if (div_st.done) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    samples.ready = state == ST_IDLE;
    div_start     = 1'b0;
    mul_start     = 1'b0;
    div_num       = DIV_W'(x_sum);
    div_den       = ADC_BITS'(SAMPLES_PER_AXIS);
    mul_a         = screen_height;
    mul_b         = ay - y_min;
    case (state)
      ST_IDLE: begin
        div_start = last;
      end
      ST_DIV_X: begin
        div_num   = DIV_W'(y_sum);
        div_start = div_st.done;
      end
      ST_CHECK: begin
        mul_a     = screen_width;
        mul_b     = ax - x_min;
        mul_start = in_range;
      end
      ST_MUL_X: begin
        div_num   = mul_p;
        div_den   = span_x;
        div_start = mul_st.done && !span_x_zero;
        mul_start = mul_st.done && span_x_zero;
      end
      ST_DIVS_X: begin
        mul_start = div_st.done;
      end
      ST_MUL_Y: begin
        div_num   = mul_p;
        div_den   = span_y;
        div_start = mul_st.done && !span_y_zero;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      x_sum       <= '0;
      y_sum       <= '0;
      x_min       <= ADC_BITS'(DEF_X_MIN);
      x_max       <= ADC_BITS'(DEF_X_MAX);
      y_min       <= ADC_BITS'(DEF_Y_MIN);
      y_max       <= ADC_BITS'(DEF_Y_MAX);
      first_x     <= '0;
      first_y     <= '0;
      first_taken <= 1'b0;
      calibrating <= 1'b1;
      touches     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        if (is_cmd) begin
          x_min       <= ADC_BITS'(DEF_X_MIN);
          x_max       <= ADC_BITS'(DEF_X_MAX);
          y_min       <= ADC_BITS'(DEF_Y_MIN);
          y_max       <= ADC_BITS'(DEF_Y_MAX);
          first_taken <= 1'b0;
          calibrating <= 1'b1;
          idx         <= '0;
          x_sum       <= '0;
          y_sum       <= '0;
        end else begin
          if (idx < Y_IDX) x_sum <= x_sum + SUM_W'(s);
          else             y_sum <= y_sum + SUM_W'(s);
          idx <= last ? '0 : idx + 1'b1;
        end
      end

      if (state == ST_CHECK) begin
        x_sum <= '0;
        y_sum <= '0;
        if (calibrating) begin
          if (!first_taken) begin
            first_x     <= ax;
            first_y     <= ay;
            first_taken <= 1'b1;
          end else begin
            // second point: smaller coordinate becomes the min
            if (first_x < ax) begin
              x_min <= first_x;
              x_max <= ax;
            end else begin
              x_min <= ax;
              x_max <= first_x;
            end
            if (first_y < ay) begin
              y_min <= first_y;
              y_max <= ay;
            end else begin
              y_min <= ay;
              y_max <= first_y;
            end
            first_taken <= 1'b0;
            calibrating <= 1'b0;
          end
        end
      end

      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
        touches   <= touches + 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_DIV_X:  if (div_st.done) ax <= ADC_BITS'(div_q);
      ST_DIV_Y:  if (div_st.done) ay <= ADC_BITS'(div_q);
      ST_CHECK: begin
        xo          <= POS_W'(ax);
        yo          <= POS_W'(ay);
        valid_q     <= in_range;
        cal_touch_q <= calibrating;
        cal_done_q  <= calibrating && first_taken;
      end
      ST_MUL_X:  if (mul_st.done && span_x_zero) xo <= '0;
      ST_DIVS_X: if (div_st.done) xo <= POS_W'(div_q);
      ST_MUL_Y:  if (mul_st.done && span_y_zero) yo <= '0;
      ST_DIVS_Y: if (div_st.done) yo <= POS_W'(div_q);
      default: ;
    endcase

    if (state == ST_OUT && out_free) begin
      results.x_pos             <= xo;
      results.y_pos             <= yo;
      results.valid_res         <= valid_q;
      results.calibration_touch <= cal_touch_q;
      results.calibration_done  <= cal_done_q;
      results.touch_count       <= touches + 1'b1;
    end
  end

  assign results.valid = out_valid;

endmodule
